/* design/x10rpd_pkg.sv */
// Shared widths, register indexes, reset values and payload types of the X10 pulse decoder.
package x10rpd_pkg;

    localparam int unsigned DUR_W  = 16;
    localparam int unsigned PCT_W  = 7;
    localparam int unsigned CNT_W  = 7;
    localparam int unsigned DATA_W = 64;
    localparam int unsigned IDX_W  = 3;

    // Product of short unit and percent, and the reciprocal used to divide it by 100.
    localparam int unsigned PROD_W       = DUR_W + PCT_W;
    localparam int unsigned MAGIC_W      = 31;
    localparam int unsigned RECIP_W      = PROD_W + MAGIC_W;
    localparam logic [MAGIC_W-1:0] DIV100_MAGIC = 31'h51EB851F;
    localparam int unsigned DIV100_SHIFT = 37;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_SHORT_UNIT  = 3'd0;
    localparam logic [IDX_W-1:0] REG_LONG_UNIT   = 3'd1;
    localparam logic [IDX_W-1:0] REG_FIXED_TOL   = 3'd2;
    localparam logic [IDX_W-1:0] REG_TOL_PERCENT = 3'd3;
    localparam logic [IDX_W-1:0] REG_BITS_WANTED = 3'd4;

    // Configuration reset values.
    localparam logic [DUR_W-1:0] RST_SHORT_UNIT  = 16'd600;
    localparam logic [DUR_W-1:0] RST_LONG_UNIT   = 16'd1800;
    localparam logic [DUR_W-1:0] RST_FIXED_TOL   = 16'd0;
    localparam logic [PCT_W-1:0] RST_TOL_PERCENT = 7'd25;
    localparam logic [CNT_W-1:0] RST_BITS_WANTED = 7'd32;

    typedef struct packed {
        logic             capture_start;
        logic [DUR_W-1:0] high_time;
        logic [DUR_W-1:0] low_time;
        logic             capture_end;
    } t_pulse;

    typedef struct packed {
        logic              outcome;
        logic [DATA_W-1:0] frame_bits;
        logic [CNT_W-1:0]  bit_total;
        logic [3:0]        house_code;
        logic [7:0]        button_code;
    } t_frame;

    typedef struct packed {
        logic [IDX_W-1:0] reg_index;
        logic [DUR_W-1:0] value;
    } t_cfg_wr;

    // Tolerance and its scaled copies, with a flag while they are being recomputed.
    typedef struct packed {
        logic             busy;
        logic [DUR_W-1:0] tol;
        logic [DUR_W:0]   tol2;
        logic [DUR_W+2:0] tol5;
        logic [DUR_W+2:0] tol7;
    } t_tol;

endpackage

/* design/x10rpd_chan_if.sv */
// Valid/ready channel interface carrying one payload of a given type.
interface x10rpd_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/x10_rf_pulse_decoder.sv */
// Top level of the X10 radio pulse decoder: preamble search, bit decoding and frame check.
//
//  Channel   Dir  Payload                                        Request accepted when
//  i_pulse   in   capture_start, high_time, low_time, capture_end  valid && ready
//  o_frame   out  outcome, frame_bits, bit_total, house_code,      valid && ready
//                 button_code
//  i_cfg     in   reg_index, value (register write)                valid && ready
//
// Each pulse request passes through an input register and then the decode stage, which writes
// the result register; a request is taken every cycle while the sink is ready and no
// tolerance recompute runs. A configuration write, and reset, start a tolerance recompute
// (multiply, divide by 100 through a reciprocal multiply, then scaling) with i_pulse.ready low.
// A result held by the sink stalls the decode stage; one more request can still fill the
// input register. Synchronous active-low reset restores the defaults and the preamble search.
module x10_rf_pulse_decoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    x10rpd_chan_if.sink           i_pulse,
    x10rpd_chan_if.source         o_frame,
    x10rpd_chan_if.sink           i_cfg
);

    // Decoder phase codes.
    localparam logic [1:0] PH_SEEK = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    localparam int unsigned DW  = x10rpd_pkg::DUR_W;
    localparam int unsigned CW  = x10rpd_pkg::CNT_W;
    localparam int unsigned DAW = x10rpd_pkg::DATA_W;

    // Configuration registers.
    logic [DW-1:0]                  r_short_unit;
    logic [DW-1:0]                  r_long_unit;
    logic [DW-1:0]                  r_fixed_tol;
    logic [x10rpd_pkg::PCT_W-1:0]   r_tol_percent;
    logic [CW-1:0]                  r_bits_wanted;
    logic                           w_cfg_fire;

    x10rpd_pkg::t_tol               w_tol;

    // Pipeline and decoder state.
    logic                           r_s1_valid;
    x10rpd_pkg::t_pulse             r_s1;
    logic [1:0]                     r_phase;
    logic [CW-1:0]                  r_cnt;
    logic [DAW-1:0]                 r_data;
    logic                           r_out_valid;
    x10rpd_pkg::t_frame             r_out;

    logic                           w_adv;
    logic                           w_s2_fire;
    logic                           w_in_fire;

    // Pulse classification.
    logic [DW+3:0]                  w_hi20;
    logic [DW+3:0]                  w_short16;
    logic [DW+3:0]                  w_pre_hi_diff;
    logic [DW+2:0]                  w_lo19;
    logic [DW+2:0]                  w_short8;
    logic [DW+2:0]                  w_pre_lo_diff;
    logic [DW-1:0]                  w_hi_diff;
    logic [DW-1:0]                  w_lo_short_diff;
    logic [DW-1:0]                  w_lo_long_diff;
    logic                           w_pre_match;
    logic                           w_hi_ok;
    logic                           w_lo_zero;
    logic                           w_lo_one;

    // Next state.
    logic [1:0]                     n_phase;
    logic [CW-1:0]                  n_cnt;
    logic [DAW-1:0]                 n_data;
    logic                           n_emit;
    x10rpd_pkg::t_frame             n_frame;

    // ------------------------------------------------------------------
    // Configuration port. Writes are always taken; unknown indexes are dropped.
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;
    assign w_cfg_fire  = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_unit  <= x10rpd_pkg::RST_SHORT_UNIT;
            r_long_unit   <= x10rpd_pkg::RST_LONG_UNIT;
            r_fixed_tol   <= x10rpd_pkg::RST_FIXED_TOL;
            r_tol_percent <= x10rpd_pkg::RST_TOL_PERCENT;
            r_bits_wanted <= x10rpd_pkg::RST_BITS_WANTED;
        end else if (w_cfg_fire) begin
            case (i_cfg.data.reg_index)
                x10rpd_pkg::REG_SHORT_UNIT:  r_short_unit  <= i_cfg.data.value;
                x10rpd_pkg::REG_LONG_UNIT:   r_long_unit   <= i_cfg.data.value;
                x10rpd_pkg::REG_FIXED_TOL:   r_fixed_tol   <= i_cfg.data.value;
                x10rpd_pkg::REG_TOL_PERCENT: begin
                    r_tol_percent <= i_cfg.data.value[x10rpd_pkg::PCT_W-1:0];
                end
                x10rpd_pkg::REG_BITS_WANTED: begin
                    r_bits_wanted <= i_cfg.data.value[CW-1:0];
                end
                default: ;
            endcase
        end
    end

    // The tolerance is derived state; it is rebuilt whenever a register is written.
    x10rpd_tol u_tol (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_recalc      (w_cfg_fire),
        .i_short_unit  (r_short_unit),
        .i_tol_percent (r_tol_percent),
        .i_fixed_tol   (r_fixed_tol),
        .o_tol         (w_tol)
    );

    // ------------------------------------------------------------------
    // Flow control. The decode stage moves when the result register is free
    // or being emptied; unless the tolerance is being rebuilt, the input register
    // refills when it is empty or the decode stage takes its request.
    // ------------------------------------------------------------------
    assign w_adv         = !r_out_valid || o_frame.ready;
    assign w_s2_fire     = r_s1_valid && w_adv;
    assign i_pulse.ready = !w_tol.busy && (!r_s1_valid || w_adv);
    assign w_in_fire     = i_pulse.valid && i_pulse.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (w_s2_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1 <= i_pulse.data;
        end
    end

    // ------------------------------------------------------------------
    // Pulse classification against the configured units. All compares use
    // the absolute difference, in widths wide enough that nothing wraps.
    // ------------------------------------------------------------------
    assign w_hi20        = (DW+4)'(r_s1.high_time);
    assign w_short16     = {r_short_unit, 4'b0000};
    assign w_pre_hi_diff = (w_hi20 > w_short16) ? (w_hi20 - w_short16) : (w_short16 - w_hi20);
    assign w_lo19        = (DW+3)'(r_s1.low_time);
    assign w_short8      = {r_short_unit, 3'b000};
    assign w_pre_lo_diff = (w_lo19 > w_short8) ? (w_lo19 - w_short8) : (w_short8 - w_lo19);

    // Preamble: high near 16 short units, low near 8 short units.
    assign w_pre_match = (w_pre_hi_diff < (DW+4)'(w_tol.tol7))
                      && (w_pre_lo_diff < w_tol.tol5);

    assign w_hi_diff = (r_s1.high_time > r_short_unit) ? (r_s1.high_time - r_short_unit)
                                                       : (r_short_unit - r_s1.high_time);
    assign w_lo_short_diff = (r_s1.low_time > r_short_unit) ? (r_s1.low_time - r_short_unit)
                                                            : (r_short_unit - r_s1.low_time);
    assign w_lo_long_diff = (r_s1.low_time > r_long_unit) ? (r_s1.low_time - r_long_unit)
                                                          : (r_long_unit - r_s1.low_time);

    assign w_hi_ok   = (w_hi_diff < w_tol.tol);
    assign w_lo_zero = (w_lo_short_diff < w_tol.tol);
    assign w_lo_one  = ((DW+1)'(w_lo_long_diff) < w_tol.tol2);

    // ------------------------------------------------------------------
    // Decode step. A capture start clears the decoder before the pair is
    // looked at; capture end is considered after the pair.
    // ------------------------------------------------------------------
    always_comb begin
        logic [1:0]     v_phase;
        logic [CW-1:0]  v_cnt;
        logic [DAW-1:0] v_data;
        logic           v_fin;
        logic           v_ok;

        v_phase = r_s1.capture_start ? PH_SEEK : r_phase;
        v_cnt   = r_s1.capture_start ? '0 : r_cnt;
        v_data  = r_s1.capture_start ? '0 : r_data;
        v_fin   = 1'b0;

        n_phase = v_phase;
        n_cnt   = v_cnt;
        n_data  = v_data;

        case (v_phase)
            PH_SEEK: begin
                if (w_pre_match) begin
                    n_phase = PH_DATA;
                    if (v_cnt >= r_bits_wanted) begin
                        v_fin = 1'b1;
                    end
                end
            end
            PH_DATA: begin
                if (!w_hi_ok) begin
                    v_fin = 1'b1;
                end else if (w_lo_zero || w_lo_one) begin
                    // A short low wins over a long one when both match.
                    n_data = {v_data[DAW-2:0], !w_lo_zero};
                    n_cnt  = v_cnt + CW'(1);
                    if (n_cnt >= r_bits_wanted) begin
                        v_fin = 1'b1;
                    end
                end else begin
                    v_fin = 1'b1;
                end
            end
            default: ;
        endcase

        if (!v_fin && r_s1.capture_end && (n_phase == PH_SEEK || n_phase == PH_DATA)) begin
            v_fin = 1'b1;
        end

        if (v_fin) begin
            n_phase = PH_DONE;
        end

        // Frame check: enough bits and both byte pairs complementary.
        v_ok = (n_cnt >= r_bits_wanted)
            && ((n_data[31:24] ^ n_data[23:16]) == 8'hFF)
            && ((n_data[15:8] ^ n_data[7:0]) == 8'hFF);

        n_emit              = v_fin;
        n_frame.outcome     = !v_ok;
        n_frame.frame_bits  = n_data;
        n_frame.bit_total   = n_cnt;
        n_frame.house_code  = v_ok ? n_data[31:28] : 4'h0;
        n_frame.button_code = v_ok ? {n_data[15:11], n_data[26:24]} : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK;
            r_cnt   <= '0;
            r_data  <= '0;
        end else if (w_s2_fire) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_data  <= n_data;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s2_fire) begin
            r_out_valid <= n_emit;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_fire && n_emit) begin
            r_out <= n_frame;
        end
    end

    assign o_frame.valid = r_out_valid;
    assign o_frame.data  = r_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // Every result closes the capture: the decoder must then sit in the finished phase.
    a_result_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s2_fire && n_emit) |=> (r_phase == PH_DONE))
        else $error("result emitted without finishing the capture");

    // A successful frame always carries at least the wanted number of bits.
    a_success_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frame.valid && !o_frame.data.outcome) |-> (o_frame.data.bit_total >= r_bits_wanted))
        else $error("successful frame with too few bits");

    // A failed frame reports neither a house code nor a button code.
    a_fail_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frame.valid && o_frame.data.outcome)
            |-> (o_frame.data.house_code == 4'h0 && o_frame.data.button_code == 8'h00))
        else $error("failed frame carries codes");

    // Requests are held off while the tolerance is rebuilt after reset.
    a_reset_holdoff: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_pulse.ready)
        else $error("pulse accepted before tolerance is ready");

endmodule

/* design/x10rpd_tol.sv */
// Tolerance unit: recomputes the match tolerance and its multiples after a configuration change.
module x10rpd_tol (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_recalc,
    input  logic [x10rpd_pkg::DUR_W-1:0]  i_short_unit,
    input  logic [x10rpd_pkg::PCT_W-1:0]  i_tol_percent,
    input  logic [x10rpd_pkg::DUR_W-1:0]  i_fixed_tol,
    output x10rpd_pkg::t_tol              o_tol
);

    logic [x10rpd_pkg::PROD_W-1:0]  r_prod;
    logic [x10rpd_pkg::RECIP_W-1:0] w_recip;
    logic [x10rpd_pkg::DUR_W-1:0]   w_quot;
    logic [x10rpd_pkg::DUR_W-1:0]   r_tol_b;
    logic [x10rpd_pkg::DUR_W-1:0]   r_tol;
    logic [x10rpd_pkg::DUR_W:0]     r_tol2;
    logic [x10rpd_pkg::DUR_W+2:0]   r_tol5;
    logic [x10rpd_pkg::DUR_W+2:0]   r_tol7;
    logic [1:0]                     r_busy;

    // Divide by 100 as a multiply by a reciprocal; the quotient is truncated to 16 bits.
    assign w_recip = x10rpd_pkg::RECIP_W'(r_prod)
                   * x10rpd_pkg::RECIP_W'(x10rpd_pkg::DIV100_MAGIC);
    assign w_quot  = w_recip[x10rpd_pkg::DIV100_SHIFT +: x10rpd_pkg::DUR_W];

    always_ff @(posedge i_clk) begin
        r_prod  <= x10rpd_pkg::PROD_W'(i_short_unit) * x10rpd_pkg::PROD_W'(i_tol_percent);
        r_tol_b <= (i_fixed_tol != '0) ? i_fixed_tol : w_quot;
        r_tol   <= r_tol_b;
        r_tol2  <= {r_tol_b, 1'b0};
        r_tol5  <= (x10rpd_pkg::DUR_W+3)'({r_tol_b, 2'b00})
                 + (x10rpd_pkg::DUR_W+3)'(r_tol_b);
        r_tol7  <= {r_tol_b, 3'b000} - (x10rpd_pkg::DUR_W+3)'(r_tol_b);
    end

    // Three register stages lie between the short unit and percentage and the outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_recalc) begin
            r_busy <= 2'd3;
        end else if (r_busy != 2'd0) begin
            r_busy <= r_busy - 2'd1;
        end
    end

    assign o_tol.busy = (r_busy != 2'd0);
    assign o_tol.tol  = r_tol;
    assign o_tol.tol2 = r_tol2;
    assign o_tol.tol5 = r_tol5;
    assign o_tol.tol7 = r_tol7;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the X10 radio pulse decoder: directed plan, then random captures.
`timescale 1ns / 100ps

module tb;
    import x10rpd_pkg::*;

    // Cycles to let pass after the last expected result before the block is taken as idle.
    // A request in flight only has an input register and the decode stage to pass.
    localparam int SETTLE_CYCLES = 8;
    // Watchdog limit. The slowest correct run is roughly two thousand requests, each with the
    // longest gap and the longest sink stall, plus the tolerance recomputes.
    localparam int CYCLE_LIMIT = 600000;
    // Random part: pulse pairs to send and pairs per register setting.
    localparam int RANDOM_PAIRS  = 1150;
    localparam int PAIRS_PER_SET = 120;

    // A failing frame that decoded nothing: the usual answer to noise.
    localparam t_frame EMPTY_FAIL = '{1'b1, 64'd0, 7'd0, 4'd0, 8'd0};

    typedef enum logic [1:0] {
        SEEKING,
        DECODING,
        FINISHED
    } t_dec_phase;

    typedef enum logic {
        ROW_PULSE,
        ROW_CFG
    } t_row_kind;

    // One line of the directed plan: either a pulse request or a register write. A pulse
    // row may carry a hand-written result, which then replaces the predicted one.
    typedef struct packed {
        t_row_kind kind;
        t_pulse    pulse;
        t_cfg_wr   wr;
        logic      typed;
        t_frame    want;
    } t_row;

    logic clk = 1'b0;
    logic rst_n;

    x10rpd_chan_if #(.T(t_pulse))  pulse_ch ();
    x10rpd_chan_if #(.T(t_frame))  frame_ch ();
    x10rpd_chan_if #(.T(t_cfg_wr)) cfg_ch ();

    x10_rf_pulse_decoder DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pulse (pulse_ch),
        .o_frame (frame_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Shadow copy of the configuration registers, starting from their reset values.
    logic [DUR_W-1:0] cfg_short     = RST_SHORT_UNIT;
    logic [DUR_W-1:0] cfg_long      = RST_LONG_UNIT;
    logic [DUR_W-1:0] cfg_fixed_tol = RST_FIXED_TOL;
    logic [PCT_W-1:0] cfg_pct       = RST_TOL_PERCENT;
    logic [CNT_W-1:0] cfg_want      = RST_BITS_WANTED;

    // Shadow copy of the decoder state.
    t_dec_phase        dec_phase = SEEKING;
    logic [CNT_W-1:0]  dec_count = '0;
    logic [DATA_W-1:0] dec_data  = '0;

    // Frames the decoder owes us, oldest first.
    t_frame frames_due[$];

    int  errors         = 0;
    int  pairs_used     = 0;
    int  frames_checked = 0;
    int  frames_good    = 0;
    int  settings_used  = 0;
    int  cycles         = 0;
    // Per-capture switches that turn random gaps on the request and result sides on or off.
    bit  tx_idle        = 1'b1;
    bit  rx_idle        = 1'b1;

    // ------------------------------------------------------------------------------------
    // Frame prediction
    // ------------------------------------------------------------------------------------

    function automatic int unsigned abs_diff(input int unsigned a, input int unsigned b);
        return (a > b) ? a - b : b - a;
    endfunction

    // The fixed tolerance wins when it is nonzero; otherwise it is a percentage of the
    // short unit, truncated to the register width.
    function automatic int unsigned tolerance_now();
        int unsigned prod;
        if (cfg_fixed_tol != '0) begin
            return cfg_fixed_tol;
        end
        prod = cfg_short * cfg_pct;
        return (prod / 100) & 32'hFFFF;
    endfunction

    // Ends the capture. A good frame has all its bits and both byte pairs complementary;
    // only a good frame reports house and button codes.
    function automatic t_frame close_frame();
        t_frame f;
        logic   ok;
        ok = (dec_count >= cfg_want) &&
             ((dec_data[31:24] ^ dec_data[23:16]) == 8'hFF) &&
             ((dec_data[15:8] ^ dec_data[7:0]) == 8'hFF);
        f.outcome     = ~ok;
        f.frame_bits  = dec_data;
        f.bit_total   = dec_count;
        f.house_code  = ok ? dec_data[31:28] : 4'd0;
        f.button_code = ok ? {dec_data[15:11], dec_data[26:24]} : 8'd0;
        dec_phase     = FINISHED;
        return f;
    endfunction

    // Advances the shadow decoder by one pulse pair. Returns 1 when the pair closes a frame.
    function automatic bit decode_pair(input t_pulse p, output t_frame f);
        int unsigned tol;
        int unsigned hi;
        int unsigned lo;
        int unsigned su;
        logic        bit_val;
        tol = tolerance_now();
        hi  = p.high_time;
        lo  = p.low_time;
        su  = cfg_short;
        f   = '0;
        // A new capture clears everything before the pair itself is looked at.
        if (p.capture_start) begin
            dec_phase = SEEKING;
            dec_count = '0;
            dec_data  = '0;
        end
        case (dec_phase)
            SEEKING: begin
                // Preamble is a high near sixteen short units and a low near eight.
                if (abs_diff(hi, su * 16) < tol * 7 && abs_diff(lo, su * 8) < tol * 5) begin
                    dec_phase = DECODING;
                    if (dec_count >= cfg_want) begin
                        f = close_frame();
                        return 1'b1;
                    end
                end
            end
            DECODING: begin
                if (abs_diff(hi, su) >= tol) begin
                    f = close_frame();
                    return 1'b1;
                end
                if (abs_diff(lo, su) < tol) begin
                    bit_val = 1'b0;
                end else if (abs_diff(lo, cfg_long) < tol * 2) begin
                    bit_val = 1'b1;
                end else begin
                    f = close_frame();
                    return 1'b1;
                end
                dec_data  = {dec_data[DATA_W-2:0], bit_val};
                dec_count = dec_count + 1'b1;
                if (dec_count >= cfg_want) begin
                    f = close_frame();
                    return 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (p.capture_end && dec_phase != FINISHED) begin
            f = close_frame();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------------------
    // Drivers. Every task starts and ends at a falling edge; handshakes are sampled at the
    // rising edge, where the block's registers still hold their old values.
    // ------------------------------------------------------------------------------------

    // Sends one pulse request and predicts its result on acceptance. A hand-written
    // expectation, when given, is queued instead of the predicted one.
    task automatic send_pulse(input t_pulse p, input bit typed = 1'b0, input t_frame want = '0);
        int     gap;
        t_frame f;
        bit     has_frame;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            pulse_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pulse_ch.valid <= 1'b1;
        pulse_ch.data  <= p;
        do @(posedge clk); while (!(pulse_ch.valid && pulse_ch.ready));
        // Pairs landing on a finished decoder are dropped by the block; they are not counted.
        if (p.capture_start || dec_phase != FINISHED) begin
            pairs_used++;
        end
        has_frame = decode_pair(p, f);
        if (typed) begin
            frames_due.push_back(want);
        end else if (has_frame) begin
            frames_due.push_back(f);
        end
        @(negedge clk);
    endtask

    // Writes one configuration register and updates the shadow copy on acceptance.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{idx, val};
        do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
        case (idx)
            REG_SHORT_UNIT:  cfg_short     = val;
            REG_LONG_UNIT:   cfg_long      = val;
            REG_FIXED_TOL:   cfg_fixed_tol = val;
            REG_TOL_PERCENT: cfg_pct       = val[PCT_W-1:0];
            REG_BITS_WANTED: cfg_want      = val[CNT_W-1:0];
            default: begin
            end
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Holds off requests until every expected frame has come back, then lets the pipeline
    // drain, since a pair that makes no frame may still be in flight.
    task automatic settle();
        pulse_ch.valid <= 1'b0;
        while (frames_due.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------------------------

    // A duration strictly inside the window around center, clipped to the field range.
    function automatic logic [DUR_W-1:0] near(input int unsigned center, input int unsigned span);
        int v;
        v = int'(center);
        if (span > 1) begin
            v = v + int'($urandom_range(0, 2 * (span - 1))) - int'(span - 1);
        end
        if (v < 0) begin
            v = 0;
        end else if (v > 65535) begin
            v = 65535;
        end
        return v[DUR_W-1:0];
    endfunction

    // Register setting of one random phase. Of every eight, one restores the reset values, two
    // draw plausible radio timings and five push one or more registers to an extreme.
    task automatic apply_setting(input int ph);
        int unsigned su;
        int unsigned lu;
        int unsigned ft;
        int unsigned pc;
        int unsigned bw;
        su = $urandom_range(150, 2000);
        lu = su * $urandom_range(2, 4);
        ft = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, su / 4);
        pc = $urandom_range(5, 45);
        bw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : 32;
        case (ph % 8)
            0: begin
                su = RST_SHORT_UNIT;
                lu = RST_LONG_UNIT;
                ft = RST_FIXED_TOL;
                pc = RST_TOL_PERCENT;
                bw = RST_BITS_WANTED;
            end
            2: begin
                // Widest percentage: the zero and one windows overlap.
                su = 1000;
                lu = 3000;
                ft = 0;
                pc = 100;
                bw = 64;
            end
            4: begin
                // Longest short unit whose preamble still fits the field, one-bit frames.
                su = 4095;
                lu = 65535;
                ft = 0;
                pc = 10;
                bw = 1;
            end
            5: begin
                // Top of every range: the preamble can no longer be reached.
                su = 65535;
                lu = 65535;
                ft = 0;
                pc = 100;
                bw = 64;
            end
            6: begin
                // More bits than the shift register holds.
                su = 300;
                lu = 900;
                ft = 0;
                pc = 30;
                bw = 100;
            end
            7: begin
                // Zero short unit with the smallest fixed tolerance.
                su = 0;
                lu = 65535;
                ft = 1;
                pc = 0;
                bw = 16;
            end
            default: begin
            end
        endcase
        write_reg(REG_SHORT_UNIT, su[DUR_W-1:0]);
        write_reg(REG_LONG_UNIT, lu[DUR_W-1:0]);
        write_reg(REG_FIXED_TOL, ft[DUR_W-1:0]);
        write_reg(REG_TOL_PERCENT, pc[DUR_W-1:0]);
        write_reg(REG_BITS_WANTED, bw[DUR_W-1:0]);
        settings_used++;
    endtask

    // One capture: mostly a well-formed frame with jittered timing, sometimes cut short,
    // corrupted or led by junk, and now and then pure noise.
    task automatic send_capture();
        int unsigned tol;
        int unsigned su;
        int          nbits;
        int          idx;
        int          bad_at;
        int          flip;
        int          k;
        bit          cut_short;
        logic        bit_val;
        logic [31:0] word;
        t_pulse      p;
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                p = '{1'($urandom), 16'($urandom), 16'($urandom), 1'($urandom)};
                send_pulse(p);
            end
            return;
        end
        tol = tolerance_now();
        su  = cfg_short;
        // Byte-complement pairs, with an occasional single-bit error.
        word[31:24] = 8'($urandom);
        word[23:16] = ~word[31:24];
        word[15:8]  = 8'($urandom);
        word[7:0]   = ~word[15:8];
        if ($urandom_range(0, 5) == 0) begin
            flip       = $urandom_range(0, 31);
            word[flip] = ~word[flip];
        end
        nbits     = cfg_want;
        cut_short = 1'b0;
        if ($urandom_range(0, 2) == 0) begin
            nbits     = $urandom_range(0, cfg_want);
            cut_short = 1'b1;
        end
        bad_at = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, nbits)) : -1;
        if ($urandom_range(0, 3) == 0) begin
            // Junk ahead of the preamble while the decoder hunts for it.
            send_pulse('{1'b1, 16'($urandom), 16'($urandom), 1'b0});
            p.capture_start = 1'b0;
        end else begin
            p.capture_start = 1'b1;
        end
        p.high_time   = near(su * 16, tol * 7);
        p.low_time    = near(su * 8, tol * 5);
        p.capture_end = cut_short && nbits == 0;
        send_pulse(p);
        for (k = 0; k < nbits; k++) begin
            if (k == bad_at) begin
                send_pulse('{1'b0, 16'($urandom), 16'($urandom), 1'b0});
            end
            // The last 32 bits sent carry the checked word; earlier ones are random.
            idx     = nbits - 1 - k;
            bit_val = (idx < 32) ? word[idx] : 1'($urandom);
            p.capture_start = 1'b0;
            p.high_time     = near(su, tol);
            p.low_time      = bit_val ? near(cfg_long, tol * 2) : near(su, tol);
            p.capture_end   = cut_short && k == nbits - 1;
            send_pulse(p);
        end
        if ($urandom_range(0, 4) == 0) begin
            send_pulse('{1'b0, 16'($urandom), 16'($urandom), 1'($urandom)});
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Directed plan
    // ------------------------------------------------------------------------------------

    function automatic t_row mk_pulse(input bit s, input int unsigned hi, input int unsigned lo,
                                      input bit e, input bit typed = 1'b0,
                                      input t_frame want = '0);
        t_row r;
        r.kind  = ROW_PULSE;
        r.pulse = '{s, 16'(hi), 16'(lo), e};
        r.wr    = '0;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic t_row mk_cfg(input logic [IDX_W-1:0] idx, input int unsigned val);
        t_row r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.wr    = '{idx, 16'(val)};
        return r;
    endfunction

    // ------------------------------------------------------------------------------------
    // Result sink and checker
    // ------------------------------------------------------------------------------------

    // The sink draws a stall before each result it is willing to take.
    initial begin : frame_sink
        int stall;
        frame_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stall = rx_idle ? $urandom_range(0, 16) : 0;
            if (stall != 0) begin
                frame_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            frame_ch.ready <= 1'b1;
            do @(posedge clk); while (!(frame_ch.valid && frame_ch.ready));
            @(negedge clk);
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] seen);
        if (seen !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, seen);
        end
    endtask

    always @(posedge clk) begin : frame_check
        t_frame got;
        t_frame exp;
        if (rst_n && frame_ch.valid && frame_ch.ready) begin
            got = frame_ch.data;
            if (frames_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected frame, expected none, got %h", $time, got);
            end else begin
                exp = frames_due.pop_front();
                frames_checked++;
                if (exp.outcome == 1'b0) begin
                    frames_good++;
                end
                check_field("outcome", exp.outcome, got.outcome);
                check_field("frame_bits", exp.frame_bits, got.frame_bits);
                check_field("bit_total", exp.bit_total, got.bit_total);
                check_field("house_code", exp.house_code, got.house_code);
                check_field("button_code", exp.button_code, got.button_code);
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------------------

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles with %0d frames outstanding",
                 cycles, frames_due.size());
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------------------

    initial begin : stimulus
        t_row plan[$];
        int   ph;
        int   phase_start;
        // Every input is known from time zero, with reset asserted.
        rst_n          = 1'b0;
        pulse_ch.valid = 1'b0;
        pulse_ch.data  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;

        // Reset timing: short 600, long 1800, tolerance 150, 32 bits wanted.
        // All-zero and all-one pairs are plain noise.
        plan.push_back(mk_pulse(1'b1, 0, 0, 1'b1, 1'b1, EMPTY_FAIL));
        plan.push_back(mk_pulse(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, EMPTY_FAIL));
        // Preamble, a one, then a zero with the end of capture: two bits, too few.
        plan.push_back(mk_pulse(1'b1, 9600, 4800, 1'b0));
        plan.push_back(mk_pulse(1'b0, 600, 1800, 1'b0));
        plan.push_back(mk_pulse(1'b0, 600, 600, 1'b1, 1'b1,
                                t_frame'{1'b1, 64'h2, 7'd2, 4'd0, 8'd0}));
        // With no bits wanted the preamble alone ends the capture, and an empty frame fails.
        // The pair after it lands on a finished decoder and is dropped, end flag and all.
        plan.push_back(mk_cfg(REG_BITS_WANTED, 0));
        plan.push_back(mk_pulse(1'b1, 9600, 4800, 1'b0, 1'b1, EMPTY_FAIL));
        plan.push_back(mk_pulse(1'b0, 600, 600, 1'b1));
        // Four-bit frames, timing one step inside each window edge: 1, 0, 1, 1.
        plan.push_back(mk_cfg(REG_BITS_WANTED, 4));
        plan.push_back(mk_pulse(1'b1, 10649, 4051, 1'b0));
        plan.push_back(mk_pulse(1'b0, 749, 1501, 1'b0));
        plan.push_back(mk_pulse(1'b0, 451, 749, 1'b0));
        plan.push_back(mk_pulse(1'b0, 600, 1800, 1'b0));
        plan.push_back(mk_pulse(1'b0, 600, 1800, 1'b0, 1'b1,
                                t_frame'{1'b1, 64'hB, 7'd4, 4'd0, 8'd0}));
        // A high exactly one tolerance off, then a low between both windows, stop decoding.
        plan.push_back(mk_pulse(1'b1, 9600, 4800, 1'b0));
        plan.push_back(mk_pulse(1'b0, 750, 600, 1'b0, 1'b1, EMPTY_FAIL));
        plan.push_back(mk_pulse(1'b1, 9600, 4800, 1'b0));
        plan.push_back(mk_pulse(1'b0, 600, 1200, 1'b0, 1'b1, EMPTY_FAIL));
        // Zero tolerance: even a perfect preamble misses, so only the end flag finishes.
        plan.push_back(mk_cfg(REG_TOL_PERCENT, 0));
        plan.push_back(mk_pulse(1'b1, 9600, 4800, 1'b1, 1'b1, EMPTY_FAIL));
        // Largest fixed tolerance accepts nearly anything, down to zero and all-one pulses.
        plan.push_back(mk_cfg(REG_SHORT_UNIT, 100));
        plan.push_back(mk_cfg(REG_LONG_UNIT, 300));
        plan.push_back(mk_cfg(REG_TOL_PERCENT, 100));
        plan.push_back(mk_cfg(REG_FIXED_TOL, 16'hFFFF));
        plan.push_back(mk_pulse(1'b1, 0, 0, 1'b0));
        plan.push_back(mk_pulse(1'b0, 16'hFFFF, 0, 1'b0));
        plan.push_back(mk_pulse(1'b0, 0, 16'hFFFF, 1'b1));
        // A zero short unit puts the all-one high exactly one tolerance away.
        plan.push_back(mk_cfg(REG_SHORT_UNIT, 0));
        plan.push_back(mk_pulse(1'b1, 16'hFFFF, 0, 1'b0));
        plan.push_back(mk_pulse(1'b0, 16'hFFFF, 0, 1'b1));
        // Short and long units at their top value, 64 bits wanted and the fixed tolerance cleared.
        plan.push_back(mk_cfg(REG_FIXED_TOL, 0));
        plan.push_back(mk_cfg(REG_SHORT_UNIT, 16'hFFFF));
        plan.push_back(mk_cfg(REG_LONG_UNIT, 16'hFFFF));
        plan.push_back(mk_cfg(REG_BITS_WANTED, 64));
        plan.push_back(mk_pulse(1'b1, 16'hFFFF, 16'hFFFF, 1'b1));

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Register writes only go in once the decoder has drained.
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                settle();
                write_reg(plan[i].wr.reg_index, plan[i].wr.value);
            end else begin
                send_pulse(plan[i].pulse, plan[i].typed, plan[i].want);
            end
        end

        // Random phases. Each one waits for every frame to come back before rewriting the
        // registers, and the idle switches flip per capture so both busy and gappy traffic
        // show up.
        for (ph = 0; pairs_used < RANDOM_PAIRS; ph++) begin
            settle();
            apply_setting(ph);
            phase_start = pairs_used;
            while (pairs_used - phase_start < PAIRS_PER_SET) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
                send_capture();
            end
        end

        settle();
        $display("Covered %0d pulse pairs over %0d register settings after the directed plan.",
                 pairs_used, settings_used);
        $display("Checked %0d frames, %0d of them decoded as valid; %0d mismatches.",
                 frames_checked, frames_good, errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
